// ===== rtl/sawlc_pkg.sv =====
`default_nettype none
package sawlc_pkg;
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FILL  = 2'd2,
		OP_BAD   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_DONE   = 3'd0,
		KIND_EVICT  = 3'd1,
		KIND_MEMWR  = 3'd2,
		KIND_FILLRQ = 3'd3,
		KIND_REFUSE = 3'd4
	} kind_t;
endpackage
`default_nettype wire

// ===== rtl/set_assoc_writeback_lru_cache.sv =====
`default_nettype none
// Byte-wide set-associative write-back LRU cache. Tags, stamps and line bytes
// live in synchronous memories with registered reads; valid and dirty
// bits are flip-flops cleared at reset. A hit goes through tag/stamp read,
// compare and data read or write; the last fill beat is followed by a read
// or write of the requested byte. A miss emits an eviction notice if the
// victim way is valid, LINE_BYTES write-back items for a dirty victim (one
// data memory read per item) and a fill request. One item is worked on at a
// time; the next item is taken once the output register is empty or being emptied.
module set_assoc_writeback_lru_cache #(
	parameter int ADDR_BITS = 32,
	parameter int SETS = 64,
	parameter int WAYS = 4,
	parameter int LINE_BYTES = 16,
	parameter int STAMP_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] addr,
	input  wire logic [7:0]  write_data,
	input  wire logic [7:0]  fill_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic             hit,
	output logic [7:0]       read_data,
	output logic [31:0]      mem_addr,
	output logic [7:0]       mem_data,
	output logic [5:0]       evict_set,
	output logic [21:0]      evict_tag,
	output logic             last
);
	localparam int OB = $clog2(LINE_BYTES);
	localparam int SB = $clog2(SETS);
	localparam int TB = (ADDR_BITS > OB + SB) ? ADDR_BITS - OB - SB : 1;
	localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NW = SETS * WAYS;
	localparam int SLB = $clog2(NW);
	localparam int DB = $clog2(NW * LINE_BYTES);
	localparam int SBI = (SB > 0) ? SB : 1;
	localparam int OBI = (OB > 0) ? OB : 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOOK, ST_DATA, ST_WB, ST_FILLRQ, ST_DONE_RD
	} state_t;

	logic [WAYS-1:0][TB-1:0]         tag_mem [SETS];
	logic [WAYS-1:0][STAMP_BITS-1:0] stamp_mem [SETS];
	logic [7:0]            data_mem [NW * LINE_BYTES];
	logic [NW-1:0]         valid_q, dirty_q;

	logic [WAYS-1:0][TB-1:0]         tags_rd;
	logic [WAYS-1:0][STAMP_BITS-1:0] stamps_rd;
	logic [7:0]                      data_rd;
	logic [DB-1:0]                   data_raddr;
	logic                            data_re;

	state_t state_q;
	logic [STAMP_BITS-1:0] clock_q;
	logic miss_q, pwrite_q;
	logic [ADDR_BITS-1:0] paddr_q, caddr_q;
	logic [7:0] pbyte_q, cbyte_q;
	logic [WB-1:0] vway_q;
	logic [OB:0] fcnt_q, wcnt_q;
	logic cwrite_q, chit_q;
	logic [TB-1:0] vtag_q;
	logic rd_pend_q;

	logic [SBI-1:0] cset, pset;
	logic [TB-1:0] ctag, ptag;
	logic [OBI-1:0] coff, poff;
	logic [SLB-1:0] cbase;
	logic lhit;
	logic [WB-1:0] lhit_way, lvict;
	logic [WAYS-1:0] vset;
	logic [ADDR_BITS-1:0] in_addr;

	assign in_addr = ADDR_BITS'(addr);
	assign cset = (SB > 0) ? SBI'(caddr_q >> OB) : '0;
	assign ctag = TB'(caddr_q >> (OB + SB));
	assign coff = (OB > 0) ? OBI'(caddr_q) : '0;
	assign pset = (SB > 0) ? SBI'(paddr_q >> OB) : '0;
	assign ptag = TB'(paddr_q >> (OB + SB));
	assign poff = (OB > 0) ? OBI'(paddr_q) : '0;
	assign cbase = SLB'(cset) * SLB'(WAYS);

	always_comb begin
		for (int w = 0; w < WAYS; w++) vset[w] = valid_q[cbase + SLB'(w)];
	end

	sawlc_lru_pick #(.WAYS(WAYS), .STAMP_BITS(STAMP_BITS), .TAG_W(TB)) u_pick (
		.valid(vset), .tags(tags_rd), .stamps(stamps_rd), .tag(ctag),
		.hit(lhit), .hit_way(lhit_way), .victim(lvict)
	);

	logic out_free;
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;

	logic [SLB-1:0] vslot;
	assign vslot = cbase + SLB'(vway_q);
	logic [SLB-1:0] pslot;
	assign pslot = SLB'(pset) * SLB'(WAYS) + SLB'(vway_q);

	// Memories: reads registered, one write port each.
	logic tag_we, stamp_we, data_we;
	logic [SBI-1:0] stamp_ws;
	logic [WB-1:0] stamp_ww;
	logic [DB-1:0] data_wa;
	logic [7:0] data_wd;
	logic [SBI-1:0] rd_set;

	always_ff @(posedge clk) begin
		tags_rd   <= tag_mem[rd_set];
		stamps_rd <= stamp_mem[rd_set];
		if (data_re) data_rd <= data_mem[data_raddr];
		if (tag_we) tag_mem[pset][vway_q] <= ptag;
		if (stamp_we) stamp_mem[stamp_ws][stamp_ww] <= clock_q + 1'b1;
		if (data_we) data_mem[data_wa] <= data_wd;
	end
	// Stamps need no reset: only valid ways, which were stamped on fill, are compared.

	logic accept;
	assign accept = in_valid && in_ready;
	assign rd_set = (SB > 0) ? SBI'(in_addr >> OB) : '0;

	logic refuse;
	assign refuse = sawlc_pkg::op_t'(op) == sawlc_pkg::OP_BAD
		|| (sawlc_pkg::op_t'(op) != sawlc_pkg::OP_FILL && miss_q)
		|| (sawlc_pkg::op_t'(op) == sawlc_pkg::OP_FILL && !miss_q);

	// load the output register this cycle
	logic out_load;
	always_comb begin
		unique case (state_q)
			ST_IDLE:    out_load = accept && refuse;
			ST_LOOK:    out_load = !lhit && vset[lvict];
			ST_DATA:    out_load = 1'b1;
			ST_WB:      out_load = chit_q && rd_pend_q && out_free;
			ST_FILLRQ:  out_load = out_free;
			ST_DONE_RD: out_load = !rd_pend_q && out_free;
			default:    out_load = 1'b0;
		endcase
	end

	always_comb begin
		tag_we = 1'b0; stamp_we = 1'b0; data_we = 1'b0;
		stamp_ws = pset; stamp_ww = vway_q;
		data_wa = '0; data_wd = fill_data;
		data_re = 1'b0; data_raddr = '0;
		if (accept && sawlc_pkg::op_t'(op) == sawlc_pkg::OP_FILL && miss_q) begin
			data_we = 1'b1;
			if (OB == 0) data_wa = DB'(pslot);
			else data_wa = DB'(pslot) * DB'(LINE_BYTES) + DB'(fcnt_q);
			if (fcnt_q == (OB+1)'(LINE_BYTES - 1)) begin
				tag_we = 1'b1;
				stamp_we = 1'b1;
			end
		end else if (state_q == ST_LOOK && lhit) begin
			stamp_we = 1'b1;
			stamp_ws = cset;
			stamp_ww = lhit_way;
			data_raddr = DB'(cbase + SLB'(lhit_way)) * DB'(LINE_BYTES) + DB'(coff);
			if (cwrite_q) begin
				data_we = 1'b1;
				data_wa = data_raddr;
				data_wd = cbyte_q;
			end else begin
				data_re = 1'b1;
			end
		end else if (state_q == ST_WB) begin
			data_re = 1'b1;
			data_raddr = DB'(vslot) * DB'(LINE_BYTES) + DB'(wcnt_q);
		end else if (state_q == ST_DONE_RD && pwrite_q && rd_pend_q) begin
			data_we = 1'b1;
			data_wa = DB'(pslot) * DB'(LINE_BYTES) + DB'(poff);
			data_wd = pbyte_q;
		end else if (state_q == ST_DONE_RD && !pwrite_q && rd_pend_q) begin
			data_re = 1'b1;
			data_raddr = DB'(pslot) * DB'(LINE_BYTES) + DB'(poff);
		end
	end

	function automatic logic [31:0] fit32(input logic [ADDR_BITS-1:0] v);
		return 32'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0; dirty_q <= '0;
			clock_q <= '0; miss_q <= 1'b0; pwrite_q <= 1'b0;
			paddr_q <= '0; pbyte_q <= '0; vway_q <= '0; fcnt_q <= '0;
			out_valid <= 1'b0; rd_pend_q <= 1'b0;
			wcnt_q <= '0; cwrite_q <= 1'b0; chit_q <= 1'b0;
			caddr_q <= '0; cbyte_q <= '0; vtag_q <= '0;
			kind <= '0; hit <= 1'b0; read_data <= '0; mem_addr <= '0;
			mem_data <= '0; evict_set <= '0; evict_tag <= '0; last <= 1'b0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						caddr_q <= in_addr;
						cbyte_q <= write_data;
						cwrite_q <= (sawlc_pkg::op_t'(op) == sawlc_pkg::OP_WRITE);
						if (refuse) begin
							kind <= sawlc_pkg::KIND_REFUSE;
							{hit, read_data, mem_addr, mem_data, evict_set, evict_tag} <= '0;
							last <= 1'b1;
						end else if (sawlc_pkg::op_t'(op) == sawlc_pkg::OP_FILL) begin
							if (fcnt_q == (OB+1)'(LINE_BYTES - 1)) begin
								fcnt_q <= '0;
								miss_q <= 1'b0;
								valid_q[pslot] <= 1'b1;
								dirty_q[pslot] <= pwrite_q;
								clock_q <= clock_q + 1'b1;
								rd_pend_q <= 1'b1;
								state_q <= ST_DONE_RD;
							end else begin
								fcnt_q <= fcnt_q + 1'b1;
							end
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					if (lhit) begin
						clock_q <= clock_q + 1'b1;
						if (cwrite_q) dirty_q[cbase + SLB'(lhit_way)] <= 1'b1;
						chit_q <= 1'b1;
						state_q <= ST_DATA;
					end else begin
						vway_q <= lvict;
						vtag_q <= tags_rd[lvict];
						valid_q[cbase + SLB'(lvict)] <= 1'b0;
						dirty_q[cbase + SLB'(lvict)] <= 1'b0;
						miss_q <= 1'b1;
						pwrite_q <= cwrite_q;
						paddr_q <= caddr_q;
						pbyte_q <= cbyte_q;
						fcnt_q <= '0;
						wcnt_q <= '0;
						chit_q <= dirty_q[cbase + SLB'(lvict)];
						if (vset[lvict]) begin
							// eviction notice goes out now; output is free here
							state_q <= ST_WB;
							rd_pend_q <= 1'b0;
							kind <= sawlc_pkg::KIND_EVICT;
							{hit, read_data, mem_addr, mem_data} <= '0;
							evict_set <= 6'(cset);
							evict_tag <= 22'(tags_rd[lvict]);
							last <= 1'b0;
						end else begin
							state_q <= ST_FILLRQ;
						end
					end
				end
				ST_DATA: begin
					kind <= sawlc_pkg::KIND_DONE;
					hit <= 1'b1;
					read_data <= cwrite_q ? 8'd0 : data_rd;
					{mem_addr, mem_data, evict_set, evict_tag} <= '0;
					last <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_WB: begin
					// chit_q holds the victim's dirty bit here; read then emit each byte
					if (!chit_q) begin
						state_q <= ST_FILLRQ;
					end else if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else if (out_free) begin
						kind <= sawlc_pkg::KIND_MEMWR;
						{hit, read_data, evict_set, evict_tag} <= '0;
						mem_addr <= fit32((ADDR_BITS'(vtag_q) << (OB + SB))
							| (ADDR_BITS'(cset) << OB) | ADDR_BITS'(wcnt_q));
						mem_data <= data_rd;
						last <= 1'b0;
						rd_pend_q <= 1'b0;
						if (wcnt_q == (OB+1)'(LINE_BYTES - 1)) state_q <= ST_FILLRQ;
						else wcnt_q <= wcnt_q + 1'b1;
					end
				end
				ST_FILLRQ: begin
					if (out_free) begin
						kind <= sawlc_pkg::KIND_FILLRQ;
						{hit, read_data, mem_data, evict_set, evict_tag} <= '0;
						mem_addr <= fit32((ADDR_BITS'(ctag) << (OB + SB))
							| (ADDR_BITS'(cset) << OB));
						last <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_DONE_RD: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else if (out_free) begin
						kind <= sawlc_pkg::KIND_DONE;
						{hit, mem_addr, mem_data, evict_set, evict_tag} <= '0;
						read_data <= pwrite_q ? 8'd0 : data_rd;
						last <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/sawlc_lru_pick.sv =====
`default_nettype none
// Pick the victim of a set: first invalid way, else the oldest stamp (lowest way on ties).
// Also reports the hit way for a tag.
module sawlc_lru_pick #(
	parameter int WAYS = 4,
	parameter int STAMP_BITS = 32,
	parameter int TAG_W = 22
) (
	input  wire logic [WAYS-1:0]                        valid,
	input  wire logic [WAYS-1:0][TAG_W-1:0]             tags,
	input  wire logic [WAYS-1:0][STAMP_BITS-1:0]        stamps,
	input  wire logic [TAG_W-1:0]                       tag,
	output logic                                        hit,
	output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]  hit_way,
	output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]  victim
);
	localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
	logic found_inv;
	logic [STAMP_BITS-1:0] best;

	always_comb begin
		hit = 1'b0;
		hit_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valid[w] && tags[w] == tag) begin
				hit = 1'b1;
				hit_way = WB'(w);
			end
		end
		victim = '0;
		found_inv = 1'b0;
		best = stamps[0];
		for (int w = 0; w < WAYS; w++) begin
			if (!found_inv) begin
				if (!valid[w]) begin
					victim = WB'(w);
					found_inv = 1'b1;
				end else if (w > 0 && stamps[w] < best) begin
					victim = WB'(w);
					best = stamps[w];
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETS = 64;
	localparam int WAYS = 4;
	localparam int LINE_BYTES = 16;

	typedef struct packed {
		sawlc_pkg::op_t op;
		logic [31:0]    addr;
		logic [7:0]     wdata;
		logic [7:0]     fdata;
	} req_t;

	typedef struct packed {
		sawlc_pkg::kind_t kind;
		logic             hit;
		logic [7:0]       rdata;
		logic [31:0]      maddr;
		logic [7:0]       mdata;
		logic [5:0]       eset;
		logic [21:0]      etag;
		logic             last;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [31:0] addr = '0;
	logic [7:0] write_data = '0;
	logic [7:0] fill_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] kind;
	logic hit;
	logic [7:0] read_data;
	logic [31:0] mem_addr;
	logic [7:0] mem_data;
	logic [5:0] evict_set;
	logic [21:0] evict_tag;
	logic last;

	set_assoc_writeback_lru_cache u_dut (.*);

	// cache model state
	logic [21:0] m_tag [SETS*WAYS];
	logic        m_valid [SETS*WAYS];
	logic        m_dirty [SETS*WAYS];
	logic [31:0] m_stamp [SETS*WAYS];
	logic [7:0]  m_line [SETS*WAYS][LINE_BYTES];
	logic [31:0] m_clock;
	logic        m_pend;
	logic        m_pend_wr;
	logic [31:0] m_pend_addr;
	logic [7:0]  m_pend_byte;
	int          m_victim;
	int          m_fill_cnt;

	req_t pending_items [$];
	rsp_t expected_rsps [$];
	int errors = 0;
	bit stim_done = 0;

	function automatic rsp_t mk(sawlc_pkg::kind_t k, logic h, logic [7:0] rd,
			logic [31:0] ma, logic [7:0] md, logic [5:0] es, logic [21:0] et);
		rsp_t r;
		r.kind = k; r.hit = h; r.rdata = rd; r.maddr = ma; r.mdata = md;
		r.eset = es; r.etag = et; r.last = 1'b0;
		return r;
	endfunction

	task automatic push_last(ref rsp_t q[$]);
		q[$].last = 1'b1;
		foreach (q[i]) expected_rsps.push_back(q[i]);
	endtask

	task automatic predict_cache(req_t it);
		rsp_t q[$];
		logic [5:0] set;
		logic [3:0] off;
		logic [21:0] tg;
		int base, slot;
		if (it.op == sawlc_pkg::OP_FILL) begin
			if (!m_pend) begin
				q.push_back(mk(sawlc_pkg::KIND_REFUSE, 0, 0, 0, 0, 0, 0));
				push_last(q);
				return;
			end
			set = m_pend_addr[9:4]; off = m_pend_addr[3:0]; tg = m_pend_addr[31:10];
			slot = set * WAYS + m_victim;
			m_line[slot][m_fill_cnt] = it.fdata;
			if (m_fill_cnt + 1 < LINE_BYTES) begin
				m_fill_cnt++;
				return;
			end
			m_fill_cnt = 0; m_pend = 0;
			m_valid[slot] = 1; m_tag[slot] = tg; m_dirty[slot] = m_pend_wr;
			m_clock++; m_stamp[slot] = m_clock;
			if (m_pend_wr) begin
				m_line[slot][off] = m_pend_byte;
				q.push_back(mk(sawlc_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0));
			end else
				q.push_back(mk(sawlc_pkg::KIND_DONE, 0, m_line[slot][off], 0, 0, 0, 0));
			push_last(q);
			return;
		end
		if (it.op == sawlc_pkg::OP_BAD || m_pend) begin
			q.push_back(mk(sawlc_pkg::KIND_REFUSE, 0, 0, 0, 0, 0, 0));
			push_last(q);
			return;
		end
		set = it.addr[9:4]; off = it.addr[3:0]; tg = it.addr[31:10];
		base = set * WAYS;
		for (int w = 0; w < WAYS; w++) begin
			slot = base + w;
			if (m_valid[slot] && m_tag[slot] == tg) begin
				m_clock++; m_stamp[slot] = m_clock;
				if (it.op == sawlc_pkg::OP_WRITE) begin
					m_line[slot][off] = it.wdata;
					m_dirty[slot] = 1;
					q.push_back(mk(sawlc_pkg::KIND_DONE, 1, 0, 0, 0, 0, 0));
				end else
					q.push_back(mk(sawlc_pkg::KIND_DONE, 1, m_line[slot][off], 0, 0, 0, 0));
				push_last(q);
				return;
			end
		end
		m_victim = 0;
		for (int w = 0; w < WAYS; w++) begin
			if (!m_valid[base + w]) begin
				m_victim = w;
				break;
			end
			if (w > 0 && m_stamp[base + w] < m_stamp[base + m_victim]) m_victim = w;
		end
		slot = base + m_victim;
		if (m_valid[slot]) begin
			q.push_back(mk(sawlc_pkg::KIND_EVICT, 0, 0, 0, 0, set, m_tag[slot]));
			if (m_dirty[slot])
				for (int k = 0; k < LINE_BYTES; k++)
					q.push_back(mk(sawlc_pkg::KIND_MEMWR, 0, 0, {m_tag[slot], set, 4'(k)},
						m_line[slot][k], 0, 0));
		end
		m_valid[slot] = 0; m_dirty[slot] = 0;
		m_pend = 1; m_pend_wr = (it.op == sawlc_pkg::OP_WRITE);
		m_pend_addr = it.addr; m_pend_byte = it.wdata; m_fill_cnt = 0;
		q.push_back(mk(sawlc_pkg::KIND_FILLRQ, 0, 0, {tg, set, 4'd0}, 0, 0, 0));
		push_last(q);
	endtask

	function automatic req_t acc(sawlc_pkg::op_t o, logic [31:0] a, logic [7:0] d);
		req_t r;
		r.op = o; r.addr = a; r.wdata = d; r.fdata = 8'($urandom);
		return r;
	endfunction

	// a whole line of fill items
	task automatic add_fill();
		for (int k = 0; k < LINE_BYTES; k++)
			pending_items.push_back(acc(sawlc_pkg::OP_FILL, $urandom, $urandom));
	endtask

	// addresses from a small pool of tags in a few sets to force conflicts
	function automatic logic [31:0] pick_addr();
		logic [21:0] tg;
		logic [5:0] st;
		if ($urandom_range(0, 9) == 0) return $urandom;
		tg = ($urandom_range(0, 3) == 0) ? 22'($urandom) : 22'($urandom_range(0, 6));
		if ($urandom_range(0, 7) == 0) tg = 22'h3FFFFF;
		st = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 2));
		return {tg, st, 4'($urandom)};
	endfunction

	initial begin
		logic [31:0] a;
		for (int i = 0; i < SETS*WAYS; i++) begin
			m_valid[i] = 0; m_dirty[i] = 0; m_stamp[i] = 0; m_tag[i] = 0;
		end
		m_clock = 0; m_pend = 0; m_pend_wr = 0; m_pend_addr = 0;
		m_pend_byte = 0; m_victim = 0; m_fill_cnt = 0;
		// directed: refused fill, bad op, read miss, two refused accesses, fill, write hit, read hit, write miss, fill
		pending_items.push_back(acc(sawlc_pkg::OP_FILL, 0, 0));
		pending_items.push_back(acc(sawlc_pkg::OP_BAD, 32'hFFFF_FFFF, 8'hFF));
		pending_items.push_back(acc(sawlc_pkg::OP_READ, 32'h0000_0000, 0));
		pending_items.push_back(acc(sawlc_pkg::OP_WRITE, 32'h0000_0005, 8'hAA));
		pending_items.push_back(acc(sawlc_pkg::OP_READ, 32'h0000_0005, 0));
		add_fill();
		pending_items.push_back(acc(sawlc_pkg::OP_WRITE, 32'h0000_0003, 8'hFF));
		pending_items.push_back(acc(sawlc_pkg::OP_READ, 32'h0000_0003, 0));
		pending_items.push_back(acc(sawlc_pkg::OP_WRITE, 32'hFFFF_FFFF, 8'h00));
		add_fill();
		// random: mostly reads and writes, most followed by a full line of fills
		while (pending_items.size() < 360) begin
			case ($urandom_range(0, 19))
				0: pending_items.push_back(acc(sawlc_pkg::OP_BAD, $urandom, $urandom));
				1: pending_items.push_back(acc(sawlc_pkg::OP_FILL, $urandom, $urandom));
				default: begin
					a = pick_addr();
					pending_items.push_back(acc($urandom_range(0, 1) ? sawlc_pkg::OP_WRITE
						: sawlc_pkg::OP_READ, a, $urandom));
					if ($urandom_range(0, 9) == 0)
						pending_items.push_back(acc(sawlc_pkg::OP_READ, $urandom, $urandom));
					// fills are refused harmlessly when the access hit
					if ($urandom_range(0, 2) != 0) add_fill();
				end
			endcase
		end
		add_fill();
	end

	initial forever #2 clk = ~clk;

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	int gap_left = 0;
	int burst_left = 0;
	int stall_phase = 0;

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (in_valid)
					predict_cache(req_t'{sawlc_pkg::op_t'(op), addr, write_data, fill_data});
				if (gap_left > 0 || pending_items.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left > 0) gap_left--;
					if (pending_items.size() == 0) stim_done <= 1'b1;
				end else begin
					req_t it;
					it = pending_items.pop_front();
					in_valid <= 1'b1;
					op <= it.op; addr <= it.addr;
					write_data <= it.wdata; fill_data <= it.fdata;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
					end else
						burst_left--;
				end
			end
		end
	end

	// receiver stall pattern plus monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				rsp_t got, exp_r;
				got = '{sawlc_pkg::kind_t'(kind), hit, read_data, mem_addr, mem_data,
					evict_set, evict_tag, last};
				if (expected_rsps.size() == 0) begin
					$error("unexpected result kind=%0d", kind);
					errors++;
				end else begin
					exp_r = expected_rsps.pop_front();
					if (got.kind !== exp_r.kind) begin
						$error("kind exp %0d got %0d", exp_r.kind, got.kind); errors++; end
					if (got.hit !== exp_r.hit) begin
						$error("hit exp %0d got %0d", exp_r.hit, got.hit); errors++; end
					if (got.rdata !== exp_r.rdata) begin
						$error("read_data exp %0h got %0h", exp_r.rdata, got.rdata);
						errors++; end
					if (got.maddr !== exp_r.maddr) begin
						$error("mem_addr exp %0h got %0h", exp_r.maddr, got.maddr);
						errors++; end
					if (got.mdata !== exp_r.mdata) begin
						$error("mem_data exp %0h got %0h", exp_r.mdata, got.mdata);
						errors++; end
					if (got.eset !== exp_r.eset) begin
						$error("evict_set exp %0h got %0h", exp_r.eset, got.eset);
						errors++; end
					if (got.etag !== exp_r.etag) begin
						$error("evict_tag exp %0h got %0h", exp_r.etag, got.etag);
						errors++; end
					if (got.last !== exp_r.last) begin
						$error("last exp %0d got %0d", exp_r.last, got.last); errors++; end
				end
			end
			stall_phase = (stall_phase + 1) % 200;
			out_ready <= (stall_phase < 60) ? 1'b1 : ($urandom_range(0, 2) != 0);
		end
	end

	initial begin
		wait (stim_done);
		wait (expected_rsps.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/sawlc_pkg.sv
rtl/sawlc_lru_pick.sv
rtl/set_assoc_writeback_lru_cache.sv
verif/testbench.sv
